[rtl/ialu_pkg.sv]
// ialu_pkg: operation codes and fixed constants of the integer alu
// no dependencies; imported by integer_alu_32bit_flags_unit
`default_nettype none

package ialu_pkg;

    localparam int ACTION_WIDTH = 5;
    localparam int HALF_WIDTH   = 16;
    localparam int IMM_WIDTH    = 8;

    localparam logic [HALF_WIDTH-1:0] HALF_MASK = 16'hFFFF;
    localparam int HALF_SHIFT = 16;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_ADD  = 5'd0,
        ACT_SUB  = 5'd1,
        ACT_ZERO = 5'd2,
        ACT_XOR  = 5'd3,
        ACT_OR   = 5'd4,
        ACT_NOT  = 5'd5,
        ACT_AND  = 5'd6,
        ACT_ASL  = 5'd7,
        ACT_ASR  = 5'd8,
        ACT_LSL  = 5'd9,
        ACT_LSR  = 5'd10,
        ACT_PASS = 5'd11,
        ACT_LCH  = 5'd12,
        ACT_LCL  = 5'd13,
        ACT_SLT  = 5'd14,
        ACT_SLTI = 5'd15,
        ACT_SMT  = 5'd16,
        ACT_INC  = 5'd17,
        ACT_DEC  = 5'd18,
        ACT_ADDI = 5'd19,
        ACT_SUBI = 5'd20,
        ACT_NAND = 5'd21,
        ACT_NOR  = 5'd22,
        ACT_HALT = 5'd23
    } action_t;

endpackage

`default_nettype wire

[rtl/integer_alu_32bit_flags_unit.sv]
// integer_alu_32bit_flags_unit: integer alu with zero, negative, overflow,
// carry/borrow and halt flags; depends on ialu_pkg
//
//  channel   handshake         payload
//  command   start / busy      action, operand_a, operand_b, dest_old, imm_small, imm_half
//  result    done (strobe)     result, zero_flag, negative_flag, overflow_flag,
//                              carry_flag, halt_flag
//
// one beat per cycle; each command beat is taken into the input register, then makes one pass
// through adder, shifter and logic into the result register
// busy is never raised, so a command can be given in every cycle
// the receiver cannot stall: each result is shown for one cycle with done high
// rst_n clears the valid bits of both registers; payload is not reset
`default_nettype none

module integer_alu_32bit_flags_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire  logic                                 clk,
    input  wire  logic                                 rst_n,
    input  wire  logic                                 start,
    output logic                                       busy,
    input  wire  logic [ialu_pkg::ACTION_WIDTH-1:0]    action,
    input  wire  logic [DATA_WIDTH-1:0]                operand_a,
    input  wire  logic [DATA_WIDTH-1:0]                operand_b,
    input  wire  logic [DATA_WIDTH-1:0]                dest_old,
    input  wire  logic signed [ialu_pkg::IMM_WIDTH-1:0] imm_small,
    input  wire  logic [ialu_pkg::HALF_WIDTH-1:0]      imm_half,
    output logic                                       done,
    output logic [DATA_WIDTH-1:0]                      result,
    output logic                                       zero_flag,
    output logic                                       negative_flag,
    output logic                                       overflow_flag,
    output logic                                       carry_flag,
    output logic                                       halt_flag
);

    import ialu_pkg::*;

    localparam int XW = DATA_WIDTH + HALF_SHIFT;

    logic                    in_valid_reg;
    logic [ACTION_WIDTH-1:0] action_reg;
    logic [DATA_WIDTH-1:0]   a_reg;
    logic [DATA_WIDTH-1:0]   b_reg;
    logic [DATA_WIDTH-1:0]   d_reg;
    logic [IMM_WIDTH-1:0]    imm_reg;
    logic [HALF_WIDTH-1:0]   half_reg;

    logic                    done_reg;
    logic [DATA_WIDTH-1:0]   result_reg;
    logic                    ov_reg;
    logic                    cy_reg;
    logic                    halt_reg;

    logic [DATA_WIDTH-1:0]   result_next;
    logic                    ov_next;
    logic                    cy_next;
    logic                    halt_next;

    logic [DATA_WIDTH-1:0]   imm_ext;
    logic [DATA_WIDTH-1:0]   half_mask_w;
    logic [DATA_WIDTH-1:0]   x;
    logic [DATA_WIDTH-1:0]   y;
    logic                    use_add;
    logic                    use_sub;
    logic [DATA_WIDTH:0]     sum;
    logic [DATA_WIDTH:0]     diff;
    logic [DATA_WIDTH-1:0]   shl;
    logic [XW-1:0]           lch_wide;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            action_reg <= action;
            a_reg      <= operand_a;
            b_reg      <= operand_b;
            d_reg      <= dest_old;
            imm_reg    <= imm_small;
            half_reg   <= imm_half;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
            ov_reg     <= ov_next;
            cy_reg     <= cy_next;
            halt_reg   <= halt_next;
        end
    end

    assign imm_ext     = {{(DATA_WIDTH-IMM_WIDTH){imm_reg[IMM_WIDTH-1]}}, imm_reg};
    assign half_mask_w = DATA_WIDTH'(HALF_MASK);
    assign sum         = {1'b0, x} + {1'b0, y};
    assign diff        = {1'b0, x} - {1'b0, y};
    assign shl         = a_reg << b_reg;
    assign lch_wide    = (XW'(half_reg) << HALF_SHIFT) | XW'(d_reg & half_mask_w);

    // adder operand selection
    always_comb
    begin
        x       = a_reg;
        y       = b_reg;
        use_add = 1'b0;
        use_sub = 1'b0;
        unique case (action_t'(action_reg))
            ACT_ADD:  use_add = 1'b1;
            ACT_SUB:  use_sub = 1'b1;
            ACT_INC:
            begin
                x       = d_reg;
                y       = DATA_WIDTH'(1);
                use_add = 1'b1;
            end
            ACT_DEC:
            begin
                x       = d_reg;
                y       = DATA_WIDTH'(1);
                use_sub = 1'b1;
            end
            ACT_ADDI:
            begin
                x       = b_reg;
                y       = imm_ext;
                use_add = 1'b1;
            end
            ACT_SUBI:
            begin
                x       = b_reg;
                y       = imm_ext;
                use_sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result_next = '0;
        ov_next     = 1'b0;
        cy_next     = 1'b0;
        halt_next   = 1'b0;
        if (use_add)
        begin
            result_next = sum[DATA_WIDTH-1:0];
            cy_next     = sum[DATA_WIDTH];
            ov_next     = (x[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1])
                        & (y[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1]);
        end
        else if (use_sub)
        begin
            result_next = diff[DATA_WIDTH-1:0];
            cy_next     = diff[DATA_WIDTH];
            ov_next     = (x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1])
                        & (x[DATA_WIDTH-1] ^ diff[DATA_WIDTH-1]);
        end
        else
        begin
            unique case (action_t'(action_reg))
                ACT_XOR:  result_next = a_reg ^ b_reg;
                ACT_OR:   result_next = a_reg | b_reg;
                ACT_NOT:  result_next = ~a_reg;
                ACT_AND:  result_next = a_reg & b_reg;
                ACT_ASL:  result_next = {a_reg[DATA_WIDTH-1], shl[DATA_WIDTH-2:0]};
                ACT_ASR:  result_next = DATA_WIDTH'($signed(a_reg) >>> b_reg);
                ACT_LSL:  result_next = shl;
                ACT_LSR:  result_next = a_reg >> b_reg;
                ACT_PASS: result_next = a_reg;
                ACT_LCH:  result_next = lch_wide[DATA_WIDTH-1:0];
                ACT_LCL:  result_next = (d_reg & ~half_mask_w) | DATA_WIDTH'(half_reg);
                ACT_SLT:  result_next = DATA_WIDTH'(a_reg < b_reg);
                ACT_SLTI: result_next = DATA_WIDTH'(b_reg < imm_ext);
                ACT_SMT:  result_next = DATA_WIDTH'(a_reg > b_reg);
                ACT_NAND: result_next = ~(a_reg & b_reg);
                ACT_NOR:  result_next = ~(a_reg | b_reg);
                ACT_HALT:
                begin
                    result_next = d_reg;
                    halt_next   = 1'b1;
                end
                default:  result_next = '0;
            endcase
        end
    end

    assign done          = done_reg;
    assign result        = result_reg;
    assign zero_flag     = (result_reg == '0);
    assign negative_flag = result_reg[DATA_WIDTH-1];
    assign overflow_flag = ov_reg;
    assign carry_flag    = cy_reg;
    assign halt_flag     = halt_reg;

endmodule

`default_nettype wire

[bench/integer_alu_32bit_flags_unit_tb.sv]
// integer_alu_32bit_flags_unit_tb: self-checking bench for the integer alu with flags
// drives command beats with random gaps and predicts result and flags for each beat
// depends on ialu_pkg and integer_alu_32bit_flags_unit
module integer_alu_32bit_flags_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ialu_pkg::*;

    localparam int DW = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [ACTION_WIDTH-1:0] op;
        logic [DW-1:0]           value;
        logic                    zero;
        logic                    neg;
        logic                    ovf;
        logic                    cry;
        logic                    hlt;
    } alu_outcome_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [ACTION_WIDTH-1:0]        action;
    logic [DW-1:0]                  operand_a;
    logic [DW-1:0]                  operand_b;
    logic [DW-1:0]                  dest_old;
    logic signed [IMM_WIDTH-1:0]    imm_small;
    logic [HALF_WIDTH-1:0]          imm_half;
    logic                           done;
    logic [DW-1:0]                  result;
    logic                           zero_flag;
    logic                           negative_flag;
    logic                           overflow_flag;
    logic                           carry_flag;
    logic                           halt_flag;

    alu_outcome_t awaited_outcomes[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           idle_on = 1'b1;

    integer_alu_32bit_flags_unit #(
        .DATA_WIDTH(DW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .dest_old(dest_old),
        .imm_small(imm_small),
        .imm_half(imm_half),
        .done(done),
        .result(result),
        .zero_flag(zero_flag),
        .negative_flag(negative_flag),
        .overflow_flag(overflow_flag),
        .carry_flag(carry_flag),
        .halt_flag(halt_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic alu_outcome_t compute_alu_outcome(
        input logic [ACTION_WIDTH-1:0] op,
        input logic [DW-1:0]           a,
        input logic [DW-1:0]           b,
        input logic [DW-1:0]           d,
        input logic [IMM_WIDTH-1:0]    imm,
        input logic [HALF_WIDTH-1:0]   half
    );
        alu_outcome_t      o;
        logic [DW-1:0]     imm_ext;
        logic [DW-1:0]     x;
        logic [DW-1:0]     y;
        logic [DW-1:0]     shifted;
        logic signed [DW-1:0] sa;
        logic [DW:0]       wide;
        logic              is_add;
        logic              is_sub;
        o       = '0;
        o.op    = op;
        imm_ext = {{(DW-IMM_WIDTH){imm[IMM_WIDTH-1]}}, imm};
        x       = '0;
        y       = '0;
        is_add  = 1'b0;
        is_sub  = 1'b0;
        sa      = a;
        case (op)
            ACT_ADD:  begin x = a; y = b; is_add = 1'b1; end
            ACT_SUB:  begin x = a; y = b; is_sub = 1'b1; end
            ACT_ZERO: o.value = '0;
            ACT_XOR:  o.value = a ^ b;
            ACT_OR:   o.value = a | b;
            ACT_NOT:  o.value = ~a;
            ACT_AND:  o.value = a & b;
            ACT_ASL:
            begin
                shifted = (b >= DW) ? '0 : (a << b);
                o.value = {a[DW-1], shifted[DW-2:0]};
            end
            ACT_ASR:
            begin
                if (b >= DW)
                    o.value = {DW{a[DW-1]}};
                else
                    o.value = sa >>> b;
            end
            ACT_LSL:  o.value = (b >= DW) ? '0 : (a << b);
            ACT_LSR:  o.value = (b >= DW) ? '0 : (a >> b);
            ACT_PASS: o.value = a;
            ACT_LCH:  o.value = {half, d[HALF_WIDTH-1:0]};
            ACT_LCL:  o.value = {d[DW-1:HALF_WIDTH], half};
            ACT_SLT:  o.value = DW'(a < b);
            ACT_SLTI: o.value = DW'(b < imm_ext);
            ACT_SMT:  o.value = DW'(a > b);
            ACT_INC:  begin x = d; y = 1; is_add = 1'b1; end
            ACT_DEC:  begin x = d; y = 1; is_sub = 1'b1; end
            ACT_ADDI: begin x = b; y = imm_ext; is_add = 1'b1; end
            ACT_SUBI: begin x = b; y = imm_ext; is_sub = 1'b1; end
            ACT_NAND: o.value = ~(a & b);
            ACT_NOR:  o.value = ~(a | b);
            ACT_HALT: begin o.value = d; o.hlt = 1'b1; end
            default:  o.value = '0;
        endcase
        if (is_add)
        begin
            wide    = {1'b0, x} + {1'b0, y};
            o.value = wide[DW-1:0];
            o.cry   = wide[DW];
            o.ovf   = (x[DW-1] ^ o.value[DW-1]) & (y[DW-1] ^ o.value[DW-1]);
        end
        if (is_sub)
        begin
            o.value = x - y;
            o.cry   = (x < y);
            o.ovf   = (x[DW-1] ^ y[DW-1]) & (x[DW-1] ^ o.value[DW-1]);
        end
        o.zero = (o.value == '0);
        o.neg  = o.value[DW-1];
        return o;
    endfunction

    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return DW'($urandom_range(0, 16));
            1:       return {DW{1'b1}} - DW'($urandom_range(0, 16));
            2:       return 32'h8000_0000 - 32'd16 + DW'($urandom_range(0, 32));
            3:       return DW'(1) << $urandom_range(0, DW - 1);
            default: return DW'($urandom());
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_shift_amount();
        case ($urandom_range(0, 7))
            0:       return DW'($urandom_range(DW, DW + 8));
            1:       return DW'($urandom());
            default: return DW'($urandom_range(0, DW - 1));
        endcase
    endfunction

    task automatic send_beat(
        input logic [ACTION_WIDTH-1:0] op,
        input logic [DW-1:0]           a,
        input logic [DW-1:0]           b,
        input logic [DW-1:0]           d,
        input logic [IMM_WIDTH-1:0]    imm,
        input logic [HALF_WIDTH-1:0]   half
    );
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        action    <= op;
        operand_a <= a;
        operand_b <= b;
        dest_old  <= d;
        imm_small <= imm;
        imm_half  <= half;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        awaited_outcomes.push_back(compute_alu_outcome(op, a, b, d, imm, half));
    endtask

    task automatic send_random_beat(input logic [ACTION_WIDTH-1:0] op);
        logic [DW-1:0] b;
        b = (op inside {ACT_ASL, ACT_ASR, ACT_LSL, ACT_LSR}) ? pick_shift_amount()
                                                              : pick_operand();
        send_beat(op, pick_operand(), b, pick_operand(), IMM_WIDTH'($urandom()),
                  HALF_WIDTH'($urandom()));
    endtask

    task automatic check_field(
        input string                   what,
        input logic [ACTION_WIDTH-1:0] op,
        input logic [DW-1:0]           want,
        input logic [DW-1:0]           got
    );
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s, action %0d: expected %h, actual %h",
                         what, op, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        alu_outcome_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: done %b, result %h", done, result);
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                check_field("result", want.op, want.value, result);
                check_field("zero_flag", want.op, DW'(want.zero), DW'(zero_flag));
                check_field("negative_flag", want.op, DW'(want.neg), DW'(negative_flag));
                check_field("overflow_flag", want.op, DW'(want.ovf), DW'(overflow_flag));
                check_field("carry_flag", want.op, DW'(want.cry), DW'(carry_flag));
                check_field("halt_flag", want.op, DW'(want.hlt), DW'(halt_flag));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // overflow, carry and borrow corners
    task automatic test_arith_corners();
        send_beat(ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0001, '0, '0, '0);
        send_beat(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0001, '0, '0, '0);
        send_beat(ACT_SUB, 32'h0000_0000, 32'h0000_0001, '0, '0, '0);
        send_beat(ACT_SUB, 32'h8000_0000, 32'h0000_0001, '0, '0, '0);
        send_beat(ACT_INC, '0, '0, 32'h7FFF_FFFF, '0, '0);
        send_beat(ACT_DEC, '0, '0, 32'h0000_0000, '0, '0);
        send_beat(ACT_ADDI, '0, 32'hFFFF_FFFF, '0, 8'h80, '0);
        send_beat(ACT_SUBI, '0, 32'h8000_0000, '0, 8'h7F, '0);
    endtask

    task automatic test_logic_corners();
        send_beat(ACT_ZERO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_beat(ACT_NOT, 32'h0000_0000, '0, '0, '0, '0);
        send_beat(ACT_NAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0);
        send_beat(ACT_NOR, 32'h0000_0000, 32'h0000_0000, '0, '0, '0);
        send_beat(ACT_XOR, 32'hA5A5_5A5A, 32'hA5A5_5A5A, '0, '0, '0);
    endtask

    // sign fill, kept sign bit and out-of-range amounts
    task automatic test_shift_corners();
        send_beat(ACT_ASR, 32'h8000_0000, 32'd31, '0, '0, '0);
        send_beat(ACT_ASR, 32'h8000_0001, 32'd32, '0, '0, '0);
        send_beat(ACT_ASL, 32'h8000_0001, 32'd40, '0, '0, '0);
        send_beat(ACT_LSL, 32'h8000_0001, 32'd1, '0, '0, '0);
        send_beat(ACT_LSR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0);
    endtask

    task automatic test_load_compare_corners();
        send_beat(ACT_LCH, '0, '0, 32'h1234_5678, '0, 16'hFFFF);
        send_beat(ACT_LCL, '0, '0, 32'hFFFF_0000, '0, 16'h0000);
        send_beat(ACT_SLT, 32'h0000_0001, 32'hFFFF_FFFF, '0, '0, '0);
        send_beat(ACT_SLTI, '0, 32'hFFFF_FFFE, '0, 8'hFF, '0);
        send_beat(ACT_SMT, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0, '0);
    endtask

    task automatic test_halt_and_unknown();
        send_beat(ACT_HALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, '0, '0);
        send_beat(ACTION_WIDTH'(31), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  8'hFF, 16'hFFFF);
    endtask

    task automatic test_random_arith(input int count);
        action_t ops[6] = '{ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC, ACT_ADDI, ACT_SUBI};
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_random_beat(ops[$urandom_range(0, 5)]);
        end
    endtask

    task automatic test_random_shifts(input int count);
        action_t ops[4] = '{ACT_ASL, ACT_ASR, ACT_LSL, ACT_LSR};
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_random_beat(ops[$urandom_range(0, 3)]);
        end
    endtask

    // every code, unknown ones included
    task automatic test_random_all(input int count);
        logic [ACTION_WIDTH-1:0] op;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                op = ACTION_WIDTH'($urandom_range(ACT_HALT + 1, 31));
            else
                op = ACTION_WIDTH'($urandom_range(0, ACT_HALT));
            send_random_beat(op);
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_random_beat(ACTION_WIDTH'($urandom()));
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = '0;
        operand_a = '0;
        operand_b = '0;
        dest_old  = '0;
        imm_small = '0;
        imm_half  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_arith_corners();
        test_logic_corners();
        test_shift_corners();
        test_load_compare_corners();
        test_halt_and_unknown();
        test_random_arith(400);
        test_random_shifts(300);
        test_random_all(800);
        test_back_to_back(150);

        @(negedge clk);
        start <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
